FILE: rtl/cts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cts_pkg
// shared types and codes of the token scanner: request structs, token kinds,
// character codes and field widths
// ----------------------------------------------------------------------------
package cts_pkg;

    localparam int POSITION_BITS = 24;
    localparam int LINE_BITS     = 16;
    localparam int MAX_RESULTS   = 3;
    localparam int COUNT_BITS    = $clog2(MAX_RESULTS + 1);

    // command codes
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // token kinds
    localparam logic [4:0] K_EOF     = 5'd0;
    localparam logic [4:0] K_IDENT   = 5'd1;
    localparam logic [4:0] K_NUMBER  = 5'd2;
    localparam logic [4:0] K_STRING  = 5'd3;
    localparam logic [4:0] K_ASSIGN  = 5'd4;
    localparam logic [4:0] K_EQ      = 5'd5;
    localparam logic [4:0] K_LT      = 5'd6;
    localparam logic [4:0] K_LE      = 5'd7;
    localparam logic [4:0] K_NE      = 5'd8;
    localparam logic [4:0] K_GT      = 5'd9;
    localparam logic [4:0] K_GE      = 5'd10;
    localparam logic [4:0] K_PERIOD  = 5'd11;
    localparam logic [4:0] K_COMMA   = 5'd12;
    localparam logic [4:0] K_COLON   = 5'd13;
    localparam logic [4:0] K_SEMI    = 5'd14;
    localparam logic [4:0] K_LPAREN  = 5'd15;
    localparam logic [4:0] K_RPAREN  = 5'd16;
    localparam logic [4:0] K_PLUS    = 5'd17;
    localparam logic [4:0] K_MINUS   = 5'd18;
    localparam logic [4:0] K_STAR    = 5'd19;
    localparam logic [4:0] K_SLASH   = 5'd20;
    localparam logic [4:0] K_UNKNOWN = 5'd21;

    // character codes
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    typedef struct packed {
        logic       command;
        logic [7:0] char_value;
    } cts_char_t;

    typedef struct packed {
        logic [4:0]               token_kind;
        logic [POSITION_BITS-1:0] first_offset;
        logic [POSITION_BITS-1:0] token_length;
        logic [LINE_BITS-1:0]     first_line;
        logic [LINE_BITS-1:0]     first_column;
        logic                     token_ok;
        logic                     last_of_run;
    } cts_token_t;

    // all tokens caused by one request
    typedef struct packed {
        cts_token_t [MAX_RESULTS-1:0] tok;
        logic [COUNT_BITS-1:0]        count;
    } cts_batch_t;

endpackage

`default_nettype wire

FILE: rtl/cts_scanner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cts_scanner
// scanner state and the single-pass step logic that turns one request into
// up to three tokens
// ----------------------------------------------------------------------------
module cts_scanner (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 advance,
    input  cts_pkg::cts_char_t  char_item,
    output cts_pkg::cts_batch_t batch
);
    import cts_pkg::*;

    localparam logic [3:0] M_IDLE     = 4'd0;
    localparam logic [3:0] M_IDENT    = 4'd1;
    localparam logic [3:0] M_NUMBER   = 4'd2;
    localparam logic [3:0] M_FRACTION = 4'd3;
    localparam logic [3:0] M_STRING   = 4'd4;
    localparam logic [3:0] M_COMMENT  = 4'd5;

    typedef struct packed {
        logic [POSITION_BITS-1:0] off;
        logic [LINE_BITS-1:0]     line;
        logic [LINE_BITS-1:0]     col;
        logic [POSITION_BITS-1:0] rlen;
    } pos_t;

    typedef struct packed {
        logic [3:0]               mode;
        logic [7:0]               held_byte;
        logic                     held_valid;
        logic                     quote_single;
        logic [POSITION_BITS-1:0] beg_off;
        logic [LINE_BITS-1:0]     beg_line;
        logic [LINE_BITS-1:0]     beg_col;
        pos_t                     cur;
    } scan_state_t;

    localparam scan_state_t RESET_STATE = '{
        mode:         M_IDLE,
        held_byte:    8'd0,
        held_valid:   1'b0,
        quote_single: 1'b0,
        beg_off:      '0,
        beg_line:     LINE_BITS'(1),
        beg_col:      LINE_BITS'(1),
        cur:          '{off: '0, line: LINE_BITS'(1), col: LINE_BITS'(1), rlen: '0}
    };

    function automatic logic [LINE_BITS-1:0] sat_inc(input logic [LINE_BITS-1:0] v);
        return (v == '1) ? v : v + LINE_BITS'(1);
    endfunction

    function automatic pos_t consume(input pos_t p, input logic [7:0] ch);
        pos_t r;
        r     = p;
        r.off = p.off + POSITION_BITS'(1);
        if (ch == CH_NL)
        begin
            r.line = sat_inc(p.line);
            r.col  = LINE_BITS'(1);
        end
        else
        begin
            r.col = sat_inc(p.col);
        end
        if (p.rlen != '1)
        begin
            r.rlen = p.rlen + POSITION_BITS'(1);
        end
        return r;
    endfunction

    function automatic scan_state_t begin_token(input scan_state_t s);
        scan_state_t r;
        r          = s;
        r.beg_off  = s.cur.off;
        r.beg_line = s.cur.line;
        r.beg_col  = s.cur.col;
        r.cur.rlen = '0;
        return r;
    endfunction

    function automatic cts_token_t make_tok(input scan_state_t s, input logic [4:0] kind,
                                            input logic ok);
        cts_token_t t;
        t.token_kind   = kind;
        t.first_offset = s.beg_off;
        t.token_length = s.cur.rlen;
        t.first_line   = s.beg_line;
        t.first_column = s.beg_col;
        t.token_ok     = ok;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return ch inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] ch);
        return ch inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_space(input logic [7:0] ch);
        return ch inside {CH_SPACE, CH_TAB, CH_NL, CH_CR, CH_FF, CH_VT};
    endfunction

    function automatic logic [4:0] punct_kind(input logic [7:0] ch);
        logic [4:0] k;
        case (ch)
            CH_PERIOD: k = K_PERIOD;
            CH_COMMA:  k = K_COMMA;
            CH_COLON:  k = K_COLON;
            CH_SEMI:   k = K_SEMI;
            CH_LPAREN: k = K_LPAREN;
            CH_RPAREN: k = K_RPAREN;
            CH_PLUS:   k = K_PLUS;
            CH_MINUS:  k = K_MINUS;
            CH_STAR:   k = K_STAR;
            CH_SLASH:  k = K_SLASH;
            default:   k = K_UNKNOWN;
        endcase
        return k;
    endfunction

    scan_state_t state_reg;
    scan_state_t state_next;

    always_comb
    begin
        scan_state_t                  s;
        logic [7:0]                   c;
        logic [7:0]                   h;
        logic                         used;
        logic                         go_idle;
        logic [4:0]                   pk;
        logic [COUNT_BITS-1:0]        n;
        cts_token_t [MAX_RESULTS-1:0] toks;

        s       = state_reg;
        c       = char_item.char_value;
        h       = s.held_byte;
        used    = 1'b0;
        go_idle = 1'b0;
        pk      = K_UNKNOWN;
        n       = '0;
        toks    = '0;

        // resolve a held byte against the new byte, or against end of text
        if (s.held_valid)
        begin
            s.held_valid = 1'b0;
            s.held_byte  = 8'd0;
            if (s.mode == M_NUMBER)
            begin
                if (char_item.command == CMD_BYTE && is_digit(c))
                begin
                    s.cur  = consume(s.cur, h);
                    s.mode = M_FRACTION;
                end
                else
                begin
                    toks[n] = make_tok(s, K_NUMBER, 1'b1);
                    n       = n + COUNT_BITS'(1);
                    s.mode  = M_IDLE;
                    s       = begin_token(s);
                    s.cur   = consume(s.cur, h);
                    toks[n] = make_tok(s, K_PERIOD, 1'b1);
                    n       = n + COUNT_BITS'(1);
                end
            end
            else
            begin
                s.mode = M_IDLE;
                s.cur  = consume(s.cur, h);
                if (h == CH_STAR)
                begin
                    if (char_item.command == CMD_BYTE && c == CH_GT)
                    begin
                        s.cur  = consume(s.cur, c);
                        s.mode = M_COMMENT;
                        used   = 1'b1;
                    end
                    else
                    begin
                        toks[n] = make_tok(s, K_STAR, 1'b1);
                        n       = n + COUNT_BITS'(1);
                    end
                end
                else if (char_item.command == CMD_BYTE && c == CH_EQ)
                begin
                    s.cur   = consume(s.cur, c);
                    toks[n] = make_tok(s, (h == CH_EQ) ? K_EQ : ((h == CH_LT) ? K_LE : K_GE),
                                       1'b1);
                    n       = n + COUNT_BITS'(1);
                    used    = 1'b1;
                end
                else if (char_item.command == CMD_BYTE && h == CH_LT && c == CH_GT)
                begin
                    s.cur   = consume(s.cur, c);
                    toks[n] = make_tok(s, K_NE, 1'b1);
                    n       = n + COUNT_BITS'(1);
                    used    = 1'b1;
                end
                else
                begin
                    toks[n] = make_tok(s, (h == CH_EQ) ? K_ASSIGN :
                                          ((h == CH_LT) ? K_LT : K_GT), 1'b1);
                    n       = n + COUNT_BITS'(1);
                end
            end
        end

        if (char_item.command == CMD_BYTE)
        begin
            if (!used)
            begin
                case (s.mode)
                    M_IDENT:
                    begin
                        if (is_alpha(c) || is_digit(c) || c == CH_MINUS || c == CH_UNDER)
                        begin
                            s.cur = consume(s.cur, c);
                        end
                        else
                        begin
                            toks[n] = make_tok(s, K_IDENT, 1'b1);
                            n       = n + COUNT_BITS'(1);
                            go_idle = 1'b1;
                        end
                    end
                    M_NUMBER:
                    begin
                        if (is_digit(c))
                        begin
                            s.cur = consume(s.cur, c);
                        end
                        else if (c == CH_PERIOD)
                        begin
                            s.held_byte  = c;
                            s.held_valid = 1'b1;
                        end
                        else
                        begin
                            toks[n] = make_tok(s, K_NUMBER, 1'b1);
                            n       = n + COUNT_BITS'(1);
                            go_idle = 1'b1;
                        end
                    end
                    M_FRACTION:
                    begin
                        if (is_digit(c))
                        begin
                            s.cur = consume(s.cur, c);
                        end
                        else
                        begin
                            toks[n] = make_tok(s, K_NUMBER, 1'b1);
                            n       = n + COUNT_BITS'(1);
                            go_idle = 1'b1;
                        end
                    end
                    M_STRING:
                    begin
                        s.cur = consume(s.cur, c);
                        if (c == (s.quote_single ? CH_SQUOTE : CH_DQUOTE))
                        begin
                            toks[n] = make_tok(s, K_STRING, 1'b1);
                            n       = n + COUNT_BITS'(1);
                            s.mode  = M_IDLE;
                        end
                    end
                    M_COMMENT:
                    begin
                        s.cur = consume(s.cur, c);
                        if (c == CH_NL)
                        begin
                            s.mode = M_IDLE;
                        end
                    end
                    default:
                    begin
                        go_idle = 1'b1;
                    end
                endcase

                // byte seen between tokens
                if (go_idle)
                begin
                    s.mode = M_IDLE;
                    if (is_space(c))
                    begin
                        s.cur = consume(s.cur, c);
                    end
                    else
                    begin
                        s = begin_token(s);
                        if (c == CH_STAR || c == CH_EQ || c == CH_LT || c == CH_GT)
                        begin
                            s.held_byte  = c;
                            s.held_valid = 1'b1;
                        end
                        else
                        begin
                            s.cur = consume(s.cur, c);
                            if (is_alpha(c))
                            begin
                                s.mode = M_IDENT;
                            end
                            else if (is_digit(c))
                            begin
                                s.mode = M_NUMBER;
                            end
                            else if (c == CH_DQUOTE || c == CH_SQUOTE)
                            begin
                                s.quote_single = (c == CH_SQUOTE);
                                s.mode         = M_STRING;
                            end
                            else
                            begin
                                pk      = punct_kind(c);
                                toks[n] = make_tok(s, pk, pk != K_UNKNOWN);
                                n       = n + COUNT_BITS'(1);
                            end
                        end
                    end
                end
            end
        end
        else
        begin
            // end of text: flush the open token, then eof, then back to reset
            if (s.mode == M_IDENT)
            begin
                toks[n] = make_tok(s, K_IDENT, 1'b1);
                n       = n + COUNT_BITS'(1);
            end
            else if (s.mode == M_NUMBER || s.mode == M_FRACTION)
            begin
                toks[n] = make_tok(s, K_NUMBER, 1'b1);
                n       = n + COUNT_BITS'(1);
            end
            else if (s.mode == M_STRING)
            begin
                toks[n] = make_tok(s, K_UNKNOWN, 1'b0);
                n       = n + COUNT_BITS'(1);
            end
            s.mode  = M_IDLE;
            s       = begin_token(s);
            toks[n] = make_tok(s, K_EOF, 1'b1);
            n       = n + COUNT_BITS'(1);
            s       = RESET_STATE;
        end

        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            toks[i].last_of_run = (COUNT_BITS'(i + 1) == n);
        end

        state_next  = s;
        batch.tok   = toks;
        batch.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RESET_STATE;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cts_token_buffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cts_token_buffer
// result register: holds the tokens of one request and, while the output is not
// stalled, hands them out one per cycle on the output channel
// ----------------------------------------------------------------------------
module cts_token_buffer (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 load,
    input  cts_pkg::cts_batch_t batch,
    output logic                can_load,
    output logic                token_valid,
    input  wire                 token_stall,
    output cts_pkg::cts_token_t token_item
);
    import cts_pkg::*;

    localparam int IDX_BITS = $clog2(MAX_RESULTS);

    cts_token_t [MAX_RESULTS-1:0] slot_reg;
    logic [IDX_BITS-1:0]          rd_reg;
    logic [COUNT_BITS-1:0]        count_reg;
    logic                         pop;

    assign token_valid = (count_reg != '0);
    assign token_item  = slot_reg[rd_reg];
    assign pop         = token_valid && !token_stall;
    // refill when empty or once the last held token leaves
    assign can_load    = (count_reg == '0) || (count_reg == COUNT_BITS'(1) && pop);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg <= batch.tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else if (load)
        begin
            rd_reg    <= '0;
            count_reg <= batch.count;
        end
        else if (pop)
        begin
            rd_reg    <= rd_reg + IDX_BITS'(1);
            count_reg <= count_reg - COUNT_BITS'(1);
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_BITS'(MAX_RESULTS))
        else $error("token buffer count out of range");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid |-> (token_item.last_of_run == (count_reg == COUNT_BITS'(1))))
        else $error("last_of_run does not mark the final token of a request");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (load && batch.count != '0) |=> (token_valid && rd_reg == '0))
        else $error("loaded tokens not presented from the first slot");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !load) |=> (rd_reg == $past(rd_reg) + IDX_BITS'(1)))
        else $error("read pointer did not step on a taken token");
`endif

endmodule

`default_nettype wire

FILE: rtl/cobol_token_scanner_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cobol_token_scanner_top
// streaming lexical scanner for cobol-like source text, one byte per request
// ----------------------------------------------------------------------------
// Each request carries one source byte or the end-of-text mark; the block
// returns the tokens (identifiers, numbers, strings, relational operators,
// punctuation, unknown bytes, eof) that the byte completes, each with kind,
// start offset, length, line, column and an ok flag, and last_of_run set on
// the final token of the request. Whitespace and comments (from "*>" to end
// of line) produce nothing. Flow: a request is held in the input register, is
// scanned and lands in the result register, from which its tokens are shown.
// A new byte is taken every cycle as long as each request yields at most one
// token and the output is not stalled; a request that yields more tokens (up
// to three) stalls the input until its last token leaves, since the output
// port carries one token per cycle when not stalled. End of text flushes any
// open token, emits eof and returns the scanner to offset 0, line 1, column 1.
// ----------------------------------------------------------------------------
module cobol_token_scanner_top (
    input  wire                 clk,
    input  wire                 rst_n,
    // source byte channel
    input  wire                 char_valid,
    output logic                char_stall,
    input  cts_pkg::cts_char_t  char_item,
    // token channel
    output logic                token_valid,
    input  wire                 token_stall,
    output cts_pkg::cts_token_t token_item
);
    import cts_pkg::*;

    // input register
    logic       in_valid_reg;
    cts_char_t  in_item_reg;

    // handshake between scanner and result register
    logic       advance;
    logic       can_load;
    cts_batch_t batch;

    // the held request moves on once the result register is free
    assign advance    = in_valid_reg && can_load;
    // stall only while a held request cannot move on
    assign char_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (char_valid && !char_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
        begin
            in_item_reg <= char_item;
        end
    end

    // scanner state and step logic
    cts_scanner u_scanner (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .char_item (in_item_reg),
        .batch     (batch)
    );

    // result register, drains one token per cycle while the output is not stalled
    cts_token_buffer u_token_buffer (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance),
        .batch       (batch),
        .can_load    (can_load),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_item  (token_item)
    );

endmodule

`default_nettype wire

FILE: verif/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the cobol token scanner: a queue-fed driver sends
// byte and end-of-text requests, a built-in scanner predicts every token, and
// a monitor compares each token against the oldest prediction
// ----------------------------------------------------------------------------
module tb;
    import cts_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int MAX_SHOWN      = 10;

    localparam logic [LINE_BITS-1:0]     LINE_TOP = '1;
    localparam logic [POSITION_BITS-1:0] LEN_TOP  = '1;

    // scanner modes of the predictor
    typedef enum logic [2:0] {
        SC_IDLE,
        SC_IDENT,
        SC_NUMBER,
        SC_FRACTION,
        SC_STRING,
        SC_COMMENT
    } scan_mode_t;

    // one queued request with the pacing it is sent under
    typedef struct {
        cts_char_t   req;
        int unsigned gap_pct;
        int unsigned stall_pct;
        bit          wait_drain;
    } pending_req_t;

    // clock, reset and block ports
    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       char_valid  = 1'b0;
    logic       char_stall;
    cts_char_t  char_item   = '0;
    logic       token_valid;
    logic       token_stall = 1'b0;
    cts_token_t token_item;

    // requests waiting to be sent and tokens waiting to arrive
    pending_req_t pend_q[$];
    cts_token_t   tokens_due[$];

    // pacing applied while the stimulus is built
    int unsigned gen_gap   = 0;
    int unsigned gen_stall = 0;
    bit          gen_drain = 1'b0;
    int unsigned n_added   = 0;

    // receiver stall rate, follows the request last sent
    int unsigned stall_pct = 0;

    int          fault_count  = 0;
    int          quiet_cycles = 0;
    cts_token_t  mon_want;

    // predictor state
    scan_mode_t               sc_mode;
    logic [7:0]               sc_held;
    logic                     sc_held_ok;
    logic                     sc_single_quote;
    logic [POSITION_BITS-1:0] tok_off;
    logic [LINE_BITS-1:0]     tok_line;
    logic [LINE_BITS-1:0]     tok_col;
    logic [POSITION_BITS-1:0] tok_len;
    logic [POSITION_BITS-1:0] pos_off;
    logic [LINE_BITS-1:0]     pos_line;
    logic [LINE_BITS-1:0]     pos_col;

    // tokens caused by the request being predicted
    cts_token_t run_toks [MAX_RESULTS];
    int         run_n;

    cobol_token_scanner_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .char_item   (char_item),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_item  (token_item)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // token predictor
    // ------------------------------------------------------------------

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_space(logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_NL, CH_CR, CH_FF, CH_VT};
    endfunction

    // back to offset 0, line 1, column 1 with nothing open
    function automatic void clear_scanner();
        sc_mode         = SC_IDLE;
        sc_held         = '0;
        sc_held_ok      = 1'b0;
        sc_single_quote = 1'b0;
        tok_off         = '0;
        tok_line        = LINE_BITS'(1);
        tok_col         = LINE_BITS'(1);
        tok_len         = '0;
        pos_off         = '0;
        pos_line        = LINE_BITS'(1);
        pos_col         = LINE_BITS'(1);
    endfunction

    // step the position past one byte; offset wraps, line and column stick
    function automatic void advance_over(logic [7:0] c);
        pos_off = pos_off + POSITION_BITS'(1);
        if (c == CH_NL) begin
            if (pos_line != LINE_TOP)
                pos_line = pos_line + LINE_BITS'(1);
            pos_col = LINE_BITS'(1);
        end
        else if (pos_col != LINE_TOP) begin
            pos_col = pos_col + LINE_BITS'(1);
        end
        if (tok_len != LEN_TOP)
            tok_len = tok_len + POSITION_BITS'(1);
    endfunction

    function automatic void open_token();
        tok_off  = pos_off;
        tok_line = pos_line;
        tok_col  = pos_col;
        tok_len  = '0;
    endfunction

    function automatic void add_token(logic [4:0] kind, logic ok);
        if (run_n < MAX_RESULTS) begin
            run_toks[run_n].token_kind   = kind;
            run_toks[run_n].first_offset = tok_off;
            run_toks[run_n].token_length = tok_len;
            run_toks[run_n].first_line   = tok_line;
            run_toks[run_n].first_column = tok_col;
            run_toks[run_n].token_ok     = ok;
            run_toks[run_n].last_of_run  = 1'b0;
            run_n++;
        end
    endfunction

    // a byte seen between tokens
    function automatic void scan_between(logic [7:0] c);
        if (is_space(c)) begin
            advance_over(c);
            return;
        end
        open_token();
        if (c inside {CH_STAR, CH_EQ, CH_LT, CH_GT}) begin
            sc_held    = c;
            sc_held_ok = 1'b1;
            return;
        end
        advance_over(c);
        if (is_alpha(c))
            sc_mode = SC_IDENT;
        else if (is_digit(c))
            sc_mode = SC_NUMBER;
        else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
            sc_single_quote = (c == CH_SQUOTE);
            sc_mode         = SC_STRING;
        end
        else begin
            case (c)
                CH_PERIOD: add_token(K_PERIOD, 1'b1);
                CH_COMMA:  add_token(K_COMMA, 1'b1);
                CH_COLON:  add_token(K_COLON, 1'b1);
                CH_SEMI:   add_token(K_SEMI, 1'b1);
                CH_LPAREN: add_token(K_LPAREN, 1'b1);
                CH_RPAREN: add_token(K_RPAREN, 1'b1);
                CH_PLUS:   add_token(K_PLUS, 1'b1);
                CH_MINUS:  add_token(K_MINUS, 1'b1);
                CH_SLASH:  add_token(K_SLASH, 1'b1);
                default:   add_token(K_UNKNOWN, 1'b0);
            endcase
        end
    endfunction

    function automatic void scan_byte(logic [7:0] c);
        case (sc_mode)
            SC_IDENT:
            begin
                if (is_alpha(c) || is_digit(c) || c == CH_MINUS || c == CH_UNDER) begin
                    advance_over(c);
                    return;
                end
                add_token(K_IDENT, 1'b1);
            end
            SC_NUMBER:
            begin
                if (is_digit(c)) begin
                    advance_over(c);
                    return;
                end
                if (c == CH_PERIOD) begin
                    sc_held    = c;
                    sc_held_ok = 1'b1;
                    return;
                end
                add_token(K_NUMBER, 1'b1);
            end
            SC_FRACTION:
            begin
                if (is_digit(c)) begin
                    advance_over(c);
                    return;
                end
                add_token(K_NUMBER, 1'b1);
            end
            SC_STRING:
            begin
                advance_over(c);
                if (c == (sc_single_quote ? CH_SQUOTE : CH_DQUOTE)) begin
                    add_token(K_STRING, 1'b1);
                    sc_mode = SC_IDLE;
                end
                return;
            end
            SC_COMMENT:
            begin
                advance_over(c);
                if (c == CH_NL)
                    sc_mode = SC_IDLE;
                return;
            end
            default: ;
        endcase
        sc_mode = SC_IDLE;
        scan_between(c);
    endfunction

    // settle the lookahead byte against c; returns 1 if c was used up
    function automatic bit settle_held(logic [7:0] c, bit has_next);
        logic [7:0] h;
        h          = sc_held;
        sc_held_ok = 1'b0;
        sc_held    = '0;
        if (sc_mode == SC_NUMBER) begin
            if (has_next && is_digit(c)) begin
                advance_over(h);
                sc_mode = SC_FRACTION;
                return 1'b0;
            end
            // dot without a digit after it closes the number
            add_token(K_NUMBER, 1'b1);
            sc_mode = SC_IDLE;
            open_token();
            advance_over(h);
            add_token(K_PERIOD, 1'b1);
            return 1'b0;
        end
        sc_mode = SC_IDLE;
        advance_over(h);
        if (h == CH_STAR) begin
            if (has_next && c == CH_GT) begin
                advance_over(c);
                sc_mode = SC_COMMENT;
                return 1'b1;
            end
            add_token(K_STAR, 1'b1);
            return 1'b0;
        end
        if (has_next && c == CH_EQ) begin
            advance_over(c);
            add_token(h == CH_EQ ? K_EQ : (h == CH_LT ? K_LE : K_GE), 1'b1);
            return 1'b1;
        end
        if (has_next && h == CH_LT && c == CH_GT) begin
            advance_over(c);
            add_token(K_NE, 1'b1);
            return 1'b1;
        end
        add_token(h == CH_EQ ? K_ASSIGN : (h == CH_LT ? K_LT : K_GT), 1'b1);
        return 1'b0;
    endfunction

    // predict the tokens of one accepted request and queue them
    function automatic void predict_tokens(cts_char_t r);
        bit used;
        run_n = 0;
        if (r.command == CMD_BYTE) begin
            used = 1'b0;
            if (sc_held_ok)
                used = settle_held(r.char_value, 1'b1);
            if (!used)
                scan_byte(r.char_value);
        end
        else begin
            if (sc_held_ok)
                void'(settle_held(8'h00, 1'b0));
            case (sc_mode)
                SC_IDENT:                add_token(K_IDENT, 1'b1);
                SC_NUMBER, SC_FRACTION:  add_token(K_NUMBER, 1'b1);
                SC_STRING:               add_token(K_UNKNOWN, 1'b0);
                default: ;
            endcase
            sc_mode = SC_IDLE;
            open_token();
            add_token(K_EOF, 1'b1);
            clear_scanner();
        end
        if (run_n > 0)
            run_toks[run_n-1].last_of_run = 1'b1;
        for (int i = 0; i < run_n; i++)
            tokens_due.push_back(run_toks[i]);
    endfunction

    // ------------------------------------------------------------------
    // driver: sends queued requests and predicts each one as it is taken
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            char_valid <= 1'b0;
            char_item  <= '0;
            stall_pct  <= 0;
        end
        else begin
            if (char_valid && !char_stall)
                predict_tokens(char_item);
            // the slot is free when nothing is offered or the offer was taken
            if (!char_valid || !char_stall) begin
                if (pend_q.size() != 0
                    && !(pend_q[0].wait_drain && tokens_due.size() != 0)
                    && $urandom_range(99) >= pend_q[0].gap_pct) begin
                    char_valid <= 1'b1;
                    char_item  <= pend_q[0].req;
                    stall_pct  <= pend_q[0].stall_pct;
                    void'(pend_q.pop_front());
                end
                else begin
                    char_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: random stall on the token side, compare every taken token
    // ------------------------------------------------------------------
    function automatic string tok_text(cts_token_t t);
        return $sformatf("kind %0d off %0d len %0d line %0d col %0d ok %0d last %0d",
                         t.token_kind, t.first_offset, t.token_length, t.first_line,
                         t.first_column, t.token_ok, t.last_of_run);
    endfunction

    function automatic void log_fault(bit have_want, cts_token_t e, cts_token_t a);
        if (fault_count < MAX_SHOWN) begin
            if (have_want)
                $display("token mismatch: expected %s", tok_text(e));
            else
                $display("token mismatch: no token was expected");
            $display("                actual   %s", tok_text(a));
        end
        fault_count++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            token_stall <= 1'b0;
        end
        else begin
            token_stall <= ($urandom_range(99) < stall_pct);
            if (token_valid && !token_stall) begin
                if (tokens_due.size() == 0) begin
                    log_fault(1'b0, token_item, token_item);
                end
                else begin
                    mon_want = tokens_due.pop_front();
                    if (token_item.token_kind !== mon_want.token_kind
                        || token_item.first_offset !== mon_want.first_offset
                        || token_item.token_length !== mon_want.token_length
                        || token_item.first_line !== mon_want.first_line
                        || token_item.first_column !== mon_want.first_column
                        || token_item.token_ok !== mon_want.token_ok
                        || token_item.last_of_run !== mon_want.last_of_run)
                        log_fault(1'b1, mon_want, token_item);
                end
            end
        end
    end

    // watchdog: too long without any request or token moving
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((char_valid && !char_stall) || (token_valid && !token_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb NOT OK");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    task automatic add_byte(logic [7:0] c);
        pending_req_t p;
        p.req.command    = CMD_BYTE;
        p.req.char_value = c;
        p.gap_pct        = gen_gap;
        p.stall_pct      = gen_stall;
        p.wait_drain     = gen_drain;
        gen_drain        = 1'b0;
        pend_q.push_back(p);
        n_added++;
    endtask

    task automatic add_end();
        pending_req_t p;
        p.req.command    = CMD_END;
        p.req.char_value = 8'($urandom_range(255));
        p.gap_pct        = gen_gap;
        p.stall_pct      = gen_stall;
        p.wait_drain     = gen_drain;
        gen_drain        = 1'b0;
        pend_q.push_back(p);
    endtask

    task automatic add_text(string s);
        foreach (s[i])
            add_byte(s[i]);
    endtask

    function automatic logic [7:0] rand_letter();
        return $urandom_range(1) ? 8'("A" + $urandom_range(25)) : 8'("a" + $urandom_range(25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_space();
        case ($urandom_range(5))
            0:       return CH_TAB;
            1:       return CH_NL;
            2:       return CH_CR;
            3:       return CH_FF;
            4:       return CH_VT;
            default: return CH_SPACE;
        endcase
    endfunction

    task automatic add_digits();
        repeat (1 + $urandom_range(2))
            add_byte(rand_digit());
    endtask

    // body of a string, never holding its own closing quote
    task automatic add_string_body(logic [7:0] q);
        logic [7:0] c;
        repeat ($urandom_range(5)) begin
            if ($urandom_range(7) == 0)
                c = CH_NL;
            else begin
                do
                    c = 8'($urandom_range(32, 126));
                while (c == q);
            end
            add_byte(c);
        end
    endtask

    // one mostly well-formed lexeme with random content, then maybe a gap
    task automatic add_random_token();
        logic [7:0] q;
        case ($urandom_range(12))
            0, 1:
            begin
                add_byte(rand_letter());
                repeat ($urandom_range(6)) begin
                    case ($urandom_range(3))
                        0:       add_byte(rand_letter());
                        1:       add_byte(rand_digit());
                        2:       add_byte(CH_MINUS);
                        default: add_byte(CH_UNDER);
                    endcase
                end
            end
            2: add_digits();
            3:
            begin
                add_digits();
                add_byte(CH_PERIOD);
                add_digits();
            end
            4:
            begin
                // dot after a number but no digit behind it
                add_digits();
                add_byte(CH_PERIOD);
                case ($urandom_range(3))
                    0:       add_byte(CH_PERIOD);
                    1:       add_byte(rand_letter());
                    2:       add_byte(CH_COMMA);
                    default: add_byte(rand_space());
                endcase
            end
            5:
            begin
                q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
                add_byte(q);
                add_string_body(q);
                add_byte(q);
            end
            6:
            begin
                case ($urandom_range(6))
                    0:       add_text("=");
                    1:       add_text("==");
                    2:       add_text("<");
                    3:       add_text("<=");
                    4:       add_text("<>");
                    5:       add_text(">");
                    default: add_text(">=");
                endcase
            end
            7:
            begin
                case ($urandom_range(8))
                    0:       add_byte(CH_PERIOD);
                    1:       add_byte(CH_COMMA);
                    2:       add_byte(CH_COLON);
                    3:       add_byte(CH_SEMI);
                    4:       add_byte(CH_LPAREN);
                    5:       add_byte(CH_RPAREN);
                    6:       add_byte(CH_PLUS);
                    7:       add_byte(CH_MINUS);
                    default: add_byte(CH_SLASH);
                endcase
            end
            8:
            begin
                add_text("*>");
                repeat ($urandom_range(6))
                    add_byte(8'($urandom_range(32, 126)));
                add_byte(CH_NL);
            end
            9, 10: add_byte(8'($urandom_range(255)));
            11:    add_byte(CH_STAR);
            default:
            begin
                repeat (1 + $urandom_range(2))
                    add_byte(rand_space());
            end
        endcase
        if ($urandom_range(9) < 6)
            add_byte(rand_space());
    endtask

    // end of text, sometimes with something left open before it
    task automatic add_end_of_text();
        case ($urandom_range(5))
            0:
            begin
                add_byte(CH_DQUOTE);
                add_string_body(CH_DQUOTE);
            end
            1: add_text("*>ab");
            2: add_byte($urandom_range(1) ? CH_LT : CH_STAR);
            3: add_text("12.");
            4: add_byte(rand_letter());
            default: ;
        endcase
        add_end();
    endtask

    task automatic run_phase(int unsigned gap, int unsigned stall, int unsigned n);
        int unsigned stop_at;
        gen_gap   = gap;
        gen_stall = stall;
        gen_drain = 1'b1;
        stop_at   = n_added + n;
        while (n_added < stop_at) begin
            add_random_token();
            if ($urandom_range(24) == 0)
                add_end_of_text();
        end
        add_end_of_text();
    endtask

    initial
    begin
        clear_scanner();

        // directed: identifier with hyphen and underscore, not-equal,
        // decimal followed by a lone dot, quote inside a single-quoted
        // string, comment to end of line
        add_text("Ab-_9<>1.2.x'q\"'*>\n");
        add_end();
        // lowest and highest byte are unknown tokens
        add_byte(8'h00);
        add_byte(8'hFF);
        // unterminated string with a newline inside
        add_byte(CH_DQUOTE);
        add_byte(CH_NL);
        add_end();

        // random phases: no idling, sender idle, receiver stall, both
        run_phase(0, 0, 75);
        run_phase(78, 0, 75);
        run_phase(0, 78, 75);
        run_phase(30, 30, 75);

        // reset once, released away from the clock edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // all requests taken and every predicted token seen
        while (pend_q.size() != 0 || char_valid || tokens_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
